@@ hdl/ppd_pkg.sv @@
// ----------------------------------------------------------------------------
// Point-plane distance package
// Shared widths, payload structs, codes and the saturation helper.
// ----------------------------------------------------------------------------
package ppd_pkg;

    // Coordinate format: signed CW-bit two's complement, FB fraction bits.
    localparam int CW = 32;
    localparam int FB = 16;
    // Width of a full product of two coordinates.
    localparam int PW = 2 * CW;
    // Width of the exact plane equation sum.
    localparam int NW = PW + 2;
    // Counter width for one pass over CW bits.
    localparam int CNT_W = $clog2(CW);

    typedef logic signed [CW-1:0] coord_t;

    // Side codes.
    localparam logic [1:0] SIDE_BELOW = 2'd0;
    localparam logic [1:0] SIDE_ON    = 2'd1;
    localparam logic [1:0] SIDE_ABOVE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_NORMAL_X     = 2'd0;
    localparam logic [1:0] REG_NORMAL_Y     = 2'd1;
    localparam logic [1:0] REG_NORMAL_Z     = 2'd2;
    localparam logic [1:0] REG_PLANE_OFFSET = 2'd3;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t pz;
    } point_t;

    typedef struct packed {
        coord_t     signed_distance;
        logic [1:0] side;
        coord_t     foot_x;
        coord_t     foot_y;
        coord_t     foot_z;
        logic       degenerate;
        logic       saturated;
    } result_t;

    // Working state of one step of the long division.
    typedef struct packed {
        logic [CW-1:0] rem;
        logic [CW-1:0] low;
        logic [CW-1:0] quo;
    } div_t;

    typedef struct packed {
        coord_t val;
        logic   sat;
    } clamp_t;

    typedef enum logic [1:0] {
        NORM_IDLE,
        NORM_SQUARE,
        NORM_ROOT
    } norm_state_t;

    // Clamp a value of CW+2 bits to the signed coordinate range.
    function automatic clamp_t clamp_coord(logic [CW+1:0] v);
        clamp_t r;
        r.sat = !((v[CW+1:CW-1] == 3'b000) || (v[CW+1:CW-1] == 3'b111));
        if (r.sat)
        begin
            r.val = v[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            r.val = v[CW-1:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/ppd_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring long-division step: brings in one dividend bit and decides
// one quotient bit, then hands the partial state to the next cell.
// ----------------------------------------------------------------------------
module ppd_div_cell
    import ppd_pkg::*;
(
    input  logic          clk,
    input  logic [CW-1:0] divisor,
    input  div_t          d_in,
    output div_t          d_out
);

    div_t        d_reg;
    div_t        d_next;
    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        take;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial       = {d_in.rem, d_in.low[CW-1]};
        diff        = trial - {1'b0, divisor};
        take        = (trial >= {1'b0, divisor});
        d_next.rem  = take ? diff[CW-1:0] : trial[CW-1:0];
        d_next.low  = {d_in.low[CW-2:0], 1'b0};
        d_next.quo  = {d_in.quo[CW-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

@@ hdl/ppd_div_chain.sv @@
// ----------------------------------------------------------------------------
// Divider chain
// A row of CW divider cells; the dividend's upper half must be below the
// divisor. Each cell registers its step on the way to the quotient.
// ----------------------------------------------------------------------------
module ppd_div_chain
    import ppd_pkg::*;
(
    input  logic          clk,
    input  logic [CW-1:0] divisor,
    input  logic [PW-1:0] dividend,
    output logic [CW-1:0] quotient
);

    div_t stage [CW+1];

    // The upper half of the dividend seeds the remainder.
    assign stage[0].rem = dividend[PW-1:CW];
    assign stage[0].low = dividend[CW-1:0];
    assign stage[0].quo = '0;

    for (genvar i = 0; i < CW; i++)
    begin : g_cell
        ppd_div_cell u_cell (
            .clk     (clk),
            .divisor (divisor),
            .d_in    (stage[i]),
            .d_out   (stage[i+1])
        );
    end

    assign quotient = stage[CW].quo;

endmodule

@@ hdl/ppd_norm_unit.sv @@
// ----------------------------------------------------------------------------
// Normal length unit
// Recomputes floor(sqrt(nx^2 + ny^2 + nz^2)) after a configuration write:
// three squares on one multiplier, then one root bit per cycle.
// ----------------------------------------------------------------------------
module ppd_norm_unit
    import ppd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          restart,
    input  coord_t        normal_x,
    input  coord_t        normal_y,
    input  coord_t        normal_z,
    output logic [CW-1:0] norm,
    output logic          busy
);

    norm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [PW-1:0] sq_reg, sq_next;
    logic [PW-1:0]        acc_reg, acc_next;
    logic [PW-1:0]        rad_reg, rad_next;
    logic [CW+1:0]        r_reg, r_next;
    logic [CW-1:0]        root_reg, root_next;
    logic [CW-1:0]        norm_reg, norm_next;
    coord_t               comp;
    logic [CW+3:0]        r_shift;
    logic [CW+3:0]        r_trial;
    logic [CW+3:0]        r_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= NORM_IDLE;
            cnt_reg   <= '0;
            norm_reg  <= CW'(1) << FB;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            norm_reg  <= norm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        acc_reg  <= acc_next;
        rad_reg  <= rad_next;
        r_reg    <= r_next;
        root_reg <= root_next;
    end

    // Component selected for squaring.
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    comp = normal_x;
            2'd1:    comp = normal_y;
            2'd2:    comp = normal_z;
            default: comp = '0;
        endcase
    end

    // Next state, squaring and root iteration.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sq_next    = comp * comp;
        acc_next   = acc_reg;
        rad_next   = rad_reg;
        r_next     = r_reg;
        root_next  = root_reg;
        norm_next  = norm_reg;
        r_shift    = {r_reg, rad_reg[PW-1:PW-2]};
        r_trial    = {2'b00, root_reg, 2'b01};
        r_diff     = r_shift - r_trial;

        case (state_reg)
            NORM_IDLE:
            begin
            end
            NORM_SQUARE:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next = acc_reg + sq_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = NORM_ROOT;
                    cnt_next   = '0;
                    rad_next   = acc_reg + sq_reg;
                    r_next     = '0;
                    root_next  = '0;
                end
            end
            NORM_ROOT:
            begin
                rad_next = {rad_reg[PW-3:0], 2'b00};
                if (r_shift >= r_trial)
                begin
                    r_next    = r_diff[CW+1:0];
                    root_next = {root_reg[CW-2:0], 1'b1};
                end
                else
                begin
                    r_next    = r_shift[CW+1:0];
                    root_next = {root_reg[CW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CW - 1))
                begin
                    state_next = NORM_IDLE;
                    cnt_next   = '0;
                    norm_next  = (root_next == '0) ? CW'(1) : root_next;
                end
            end
            default:
            begin
                state_next = NORM_IDLE;
            end
        endcase

        // A new write always starts the computation over.
        if (restart)
        begin
            state_next = NORM_SQUARE;
            cnt_next   = '0;
            acc_next   = '0;
        end
    end

    assign norm = norm_reg;
    assign busy = (state_reg != NORM_IDLE);

endmodule

@@ hdl/point_plane_distance_projection_core.sv @@
// ----------------------------------------------------------------------------
// Point-plane distance and projection core
// A point passes the front stages, a row of CW divider cells for the distance,
// the middle stages, a row of CW cells per axis for the step, and the output
// register, one point per cycle while busy is low. After a configuration write,
// busy stays high while the normal length is recomputed; reset loads a unit z
// normal. Results are shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module point_plane_distance_projection_core
    import ppd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  point_t        point,
    output logic          done,
    output result_t       result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [CW-1:0] cfg_data
);

    typedef struct packed {
        point_t     p;
        logic       neg;
        logic [1:0] side;
        logic       ovf;
    } side_a_t;

    typedef struct packed {
        point_t     p;
        coord_t     distance;
        logic [1:0] side;
        logic       sat;
        logic [2:0] neg;
    } side_b_t;

    // Configuration registers.
    coord_t        normal_x_reg, normal_y_reg, normal_z_reg, plane_offset_reg;
    logic [CW-1:0] norm;
    logic          norm_busy;
    logic          accept;
    logic          degen;

    // Pipeline registers.
    logic [6:0]           v_reg;
    point_t               p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg;
    logic signed [PW-1:0] prx_reg, pry_reg, prz_reg;
    logic signed [NW-1:0] num_reg;
    logic [PW-1:0]        mag_reg;
    logic                 neg4_reg, ovf4_reg;
    logic [1:0]           side4_reg, side5_reg, side6_reg, side7_reg;
    logic [CW-1:0]        quo_a;
    side_a_t              line_a_reg [CW];
    logic [CW-1:0]        va_reg;
    coord_t               dist5_reg, dist6_reg, dist7_reg;
    logic                 sat5_reg, sat6_reg, sat7_reg;
    logic signed [PW-1:0] qx_reg, qy_reg, qz_reg;
    logic [PW-1:0]        mx_reg, my_reg, mz_reg;
    logic [2:0]           neg7_reg;
    logic [CW-1:0]        quo_x, quo_y, quo_z;
    side_b_t              line_b_reg [CW];
    logic [CW-1:0]        vb_reg;
    logic                 done_reg;
    result_t              result_reg, result_next;

    // Combinational helpers.
    logic signed [NW-1:0] num_next;
    logic [NW-1:0]        num_abs;
    logic [CW+1:0]        dist_wide;
    clamp_t               dist_c;
    clamp_t               fx_c, fy_c, fz_c;
    side_a_t              sa_out;
    side_b_t              sb_out;

    assign accept    = start && !busy;
    assign busy      = norm_busy;
    assign cfg_ready = 1'b1;
    assign degen     = (normal_x_reg == '0) && (normal_y_reg == '0) &&
                       (normal_z_reg == '0);

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg     <= '0;
            normal_y_reg     <= '0;
            normal_z_reg     <= CW'(1) << FB;
            plane_offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NORMAL_X:     normal_x_reg     <= cfg_data;
                REG_NORMAL_Y:     normal_y_reg     <= cfg_data;
                REG_NORMAL_Z:     normal_z_reg     <= cfg_data;
                REG_PLANE_OFFSET: plane_offset_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ppd_norm_unit u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_valid && cfg_ready),
        .normal_x (normal_x_reg),
        .normal_y (normal_y_reg),
        .normal_z (normal_z_reg),
        .norm     (norm),
        .busy     (norm_busy)
    );

    // Valid flags of the fixed stages, the two divider rows and the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            va_reg   <= '0;
            vb_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= accept;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            va_reg   <= {va_reg[CW-2:0], v_reg[3]};
            v_reg[4] <= va_reg[CW-1];
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            vb_reg   <= {vb_reg[CW-2:0], v_reg[6]};
            done_reg <= vb_reg[CW-1];
        end
    end

    // Plane equation sum and its magnitude.
    always_comb
    begin
        num_next = NW'(prx_reg) + NW'(pry_reg) + NW'(prz_reg)
                 - (NW'(plane_offset_reg) <<< FB);
        num_abs  = num_reg[NW-1] ? (-num_reg) : num_reg;
    end

    // Front stages: products, sum, magnitude and side.
    always_ff @(posedge clk)
    begin
        p1_reg    <= point;
        prx_reg   <= normal_x_reg * p1_reg.px;
        pry_reg   <= normal_y_reg * p1_reg.py;
        prz_reg   <= normal_z_reg * p1_reg.pz;
        p2_reg    <= p1_reg;
        num_reg   <= num_next;
        p3_reg    <= p2_reg;
        mag_reg   <= num_abs[PW-1:0];
        neg4_reg  <= num_reg[NW-1];
        ovf4_reg  <= (num_abs[NW-1:CW] >= {2'b00, norm});
        p4_reg    <= p3_reg;
        if (num_reg[NW-1])
        begin
            side4_reg <= SIDE_BELOW;
        end
        else if (num_reg == '0)
        begin
            side4_reg <= SIDE_ON;
        end
        else
        begin
            side4_reg <= SIDE_ABOVE;
        end
    end

    // Distance divider row and its side line.
    ppd_div_chain u_div_dist (
        .clk      (clk),
        .divisor  (norm),
        .dividend (mag_reg),
        .quotient (quo_a)
    );

    always_ff @(posedge clk)
    begin
        line_a_reg[0] <= '{p: p4_reg, neg: neg4_reg, side: side4_reg, ovf: ovf4_reg};
        for (int i = 1; i < CW; i++)
        begin
            line_a_reg[i] <= line_a_reg[i-1];
        end
    end

    assign sa_out = line_a_reg[CW-1];

    // Signed, saturated distance.
    always_comb
    begin
        dist_wide = sa_out.neg ? (-{2'b00, quo_a}) : {2'b00, quo_a};
        dist_c    = clamp_coord(dist_wide);
        if (sa_out.ovf)
        begin
            dist_c.sat = 1'b1;
            dist_c.val = sa_out.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
    end

    // Middle stages: distance, step products and their magnitudes.
    always_ff @(posedge clk)
    begin
        dist5_reg <= dist_c.val;
        sat5_reg  <= dist_c.sat;
        side5_reg <= sa_out.side;
        p5_reg    <= sa_out.p;
        qx_reg    <= dist5_reg * normal_x_reg;
        qy_reg    <= dist5_reg * normal_y_reg;
        qz_reg    <= dist5_reg * normal_z_reg;
        dist6_reg <= dist5_reg;
        sat6_reg  <= sat5_reg;
        side6_reg <= side5_reg;
        p6_reg    <= p5_reg;
        mx_reg    <= qx_reg[PW-1] ? (-qx_reg) : qx_reg;
        my_reg    <= qy_reg[PW-1] ? (-qy_reg) : qy_reg;
        mz_reg    <= qz_reg[PW-1] ? (-qz_reg) : qz_reg;
        neg7_reg  <= {qx_reg[PW-1], qy_reg[PW-1], qz_reg[PW-1]};
        dist7_reg <= dist6_reg;
        sat7_reg  <= sat6_reg;
        side7_reg <= side6_reg;
        p7_reg    <= p6_reg;
    end

    // Step divider rows, one per axis, and their side line.
    ppd_div_chain u_div_x (
        .clk      (clk),
        .divisor  (norm),
        .dividend (mx_reg),
        .quotient (quo_x)
    );

    ppd_div_chain u_div_y (
        .clk      (clk),
        .divisor  (norm),
        .dividend (my_reg),
        .quotient (quo_y)
    );

    ppd_div_chain u_div_z (
        .clk      (clk),
        .divisor  (norm),
        .dividend (mz_reg),
        .quotient (quo_z)
    );

    always_ff @(posedge clk)
    begin
        line_b_reg[0] <= '{p: p7_reg, distance: dist7_reg, side: side7_reg,
                           sat: sat7_reg, neg: neg7_reg};
        for (int i = 1; i < CW; i++)
        begin
            line_b_reg[i] <= line_b_reg[i-1];
        end
    end

    assign sb_out = line_b_reg[CW-1];

    // Foot of the perpendicular: point minus signed step, saturated.
    always_comb
    begin
        fx_c = clamp_coord(CW'(0) + {{2{sb_out.p.px[CW-1]}}, sb_out.p.px}
               - (sb_out.neg[2] ? (-{2'b00, quo_x}) : {2'b00, quo_x}));
        fy_c = clamp_coord(CW'(0) + {{2{sb_out.p.py[CW-1]}}, sb_out.p.py}
               - (sb_out.neg[1] ? (-{2'b00, quo_y}) : {2'b00, quo_y}));
        fz_c = clamp_coord(CW'(0) + {{2{sb_out.p.pz[CW-1]}}, sb_out.p.pz}
               - (sb_out.neg[0] ? (-{2'b00, quo_z}) : {2'b00, quo_z}));

        result_next                 = '0;
        result_next.degenerate      = degen;
        if (!degen)
        begin
            result_next.signed_distance = sb_out.distance;
            result_next.side            = sb_out.side;
            result_next.foot_x          = fx_c.val;
            result_next.foot_y          = fy_c.val;
            result_next.foot_z          = fz_c.val;
            result_next.saturated       = sb_out.sat | fx_c.sat | fy_c.sat | fz_c.sat;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-plane distance core testbench
// Streams query points through the core under several plane settings and
// checks every result against a bit-exact software plane projector.
// ----------------------------------------------------------------------------
import ppd_pkg::*;

class plane_scoreboard;
    coord_t norm_x = 0;
    coord_t norm_y = 0;
    coord_t norm_z = coord_t'(1 << FB);
    coord_t offset = 0;
    result_t pending[$];
    int errors = 0;

    function void set_reg(logic [1:0] idx, coord_t val);
        case (idx)
            REG_NORMAL_X:     norm_x = val;
            REG_NORMAL_Y:     norm_y = val;
            REG_NORMAL_Z:     norm_z = val;
            REG_PLANE_OFFSET: offset = val;
            default:          ;
        endcase
    endfunction

    // Saturate a wide value to the coordinate range.
    function coord_t clamp(logic signed [127:0] v, inout logic sat);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = (128'sd1 <<< (CW - 1)) - 1;
        lo_lim = -(128'sd1 <<< (CW - 1));
        if (v > hi_lim)
        begin
            sat = 1'b1;
            return coord_t'(hi_lim);
        end
        if (v < lo_lim)
        begin
            sat = 1'b1;
            return coord_t'(lo_lim);
        end
        return coord_t'(v);
    endfunction

    // Signed distance, side and foot of the perpendicular for one point.
    function result_t project(point_t p);
        result_t r;
        logic signed [127:0] nv[3];
        logic signed [127:0] pv[3];
        logic signed [127:0] num;
        logic signed [127:0] root_w;
        logic signed [127:0] dist_w;
        logic [63:0] n2;
        logic [63:0] root;
        logic [63:0] cand;
        logic sat;
        coord_t foot[3];
        r = '0;
        if (norm_x == 0 && norm_y == 0 && norm_z == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        nv[0] = norm_x; nv[1] = norm_y; nv[2] = norm_z;
        pv[0] = p.px;   pv[1] = p.py;   pv[2] = p.pz;
        num = 0;
        n2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            num = num + nv[k] * pv[k];
            n2 = n2 + 64'(nv[k] * nv[k]);
        end
        num = num - ((128'sd0 + offset) <<< FB);
        // Integer square root of the squared normal length.
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            cand = root | (64'd1 << i);
            if (cand * cand <= n2)
                root = cand;
        end
        if (root == 0)
            root = 1;
        root_w = $signed({64'd0, root});
        sat = 1'b0;
        r.signed_distance = clamp(num / root_w, sat);
        dist_w = r.signed_distance;
        if (num < 0)
            r.side = SIDE_BELOW;
        else if (num == 0)
            r.side = SIDE_ON;
        else
            r.side = SIDE_ABOVE;
        for (int k = 0; k < 3; k++)
            foot[k] = clamp(pv[k] - (dist_w * nv[k]) / root_w, sat);
        r.foot_x = foot[0];
        r.foot_y = foot[1];
        r.foot_z = foot[2];
        r.saturated = sat;
        return r;
    endfunction

    function void note(point_t p);
        pending.push_back(project(p));
    endfunction

    function void check(result_t got);
        result_t want;
        if (pending.size() == 0)
        begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.signed_distance !== want.signed_distance)
        begin
            $error("signed_distance: expected %h, got %h", want.signed_distance,
                   got.signed_distance);
            errors++;
        end
        if (got.side !== want.side)
        begin
            $error("side: expected %0d, got %0d", want.side, got.side);
            errors++;
        end
        if (got.foot_x !== want.foot_x)
        begin
            $error("foot_x: expected %h, got %h", want.foot_x, got.foot_x);
            errors++;
        end
        if (got.foot_y !== want.foot_y)
        begin
            $error("foot_y: expected %h, got %h", want.foot_y, got.foot_y);
            errors++;
        end
        if (got.foot_z !== want.foot_z)
        begin
            $error("foot_z: expected %h, got %h", want.foot_z, got.foot_z);
            errors++;
        end
        if (got.degenerate !== want.degenerate)
        begin
            $error("degenerate: expected %b, got %b", want.degenerate, got.degenerate);
            errors++;
        end
        if (got.saturated !== want.saturated)
        begin
            $error("saturated: expected %b, got %b", want.saturated, got.saturated);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int LATENCY = 2 * CW + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam coord_t ONE = coord_t'(1 << FB);
    localparam coord_t MAXC = coord_t'(32'h7fffffff);
    localparam coord_t MINC = coord_t'(32'h80000000);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    point_t point = '0;
    logic done;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_NORMAL_X;
    logic [CW-1:0] cfg_data = '0;

    plane_scoreboard sb = new;
    bit idle_on = 1'b1;
    int cycles = 0;

    point_plane_distance_projection_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .done(done), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Record accepted requests and check results at each rising edge.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note(point);
        if (rst_n && done)
            sb.check(result);
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("point_plane_distance_projection_core: mismatch");
            $finish;
        end
    end

    task automatic send_point(point_t p);
        if (idle_on && $urandom_range(99) < 19)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        point <= p;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, coord_t val);
        drain();
        repeat (LATENCY + 8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_plane(coord_t a, coord_t b, coord_t c, coord_t d);
        write_reg(REG_NORMAL_X, a);
        write_reg(REG_NORMAL_Y, b);
        write_reg(REG_NORMAL_Z, c);
        write_reg(REG_PLANE_OFFSET, d);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom_range(0, 1) ? MAXC : MINC);
            1, 2: return coord_t'($signed($urandom_range(0, 2 * ONE)) - ONE);
            3: return coord_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic random_points(int count);
        point_t p;
        for (int i = 0; i < count; i++)
        begin
            p.px = rand_coord();
            p.py = rand_coord();
            p.pz = rand_coord();
            send_point(p);
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed points on the reset plane z = 0.
        send_point('{px: 0, py: 0, pz: 0});
        send_point('{px: MAXC, py: MAXC, pz: MAXC});
        send_point('{px: MINC, py: MINC, pz: MINC});
        send_point('{px: MAXC, py: MINC, pz: 1});
        send_point('{px: 5, py: 7, pz: -1});
        send_point('{px: ONE, py: -ONE, pz: 3 * ONE});

        // A tilted normal where a point a hair off the plane truncates to zero.
        set_plane(ONE, ONE, 0, 0);
        send_point('{px: 1, py: 0, pz: 0});
        send_point('{px: -1, py: 0, pz: 0});
        send_point('{px: ONE, py: -ONE, pz: MAXC});
        send_point('{px: MAXC, py: MAXC, pz: 0});
        send_point('{px: MINC, py: MINC, pz: 0});
        random_points(120);

        // Largest normal with the farthest offset: distances of far points saturate.
        set_plane(MAXC, MAXC, MAXC, MINC);
        send_point('{px: MAXC, py: MAXC, pz: MAXC});
        send_point('{px: MINC, py: MINC, pz: MINC});
        send_point('{px: 0, py: 0, pz: 0});
        random_points(120);

        // Most negative normal with the largest offset.
        set_plane(MINC, MINC, MINC, MAXC);
        send_point('{px: MINC, py: MAXC, pz: MINC});
        random_points(120);

        // Zero normal is degenerate.
        set_plane(0, 0, 0, ONE);
        send_point('{px: ONE, py: ONE, pz: ONE});
        random_points(40);

        // Raw unit normal, smallest nonzero length.
        set_plane(1, 0, 0, -1);
        send_point('{px: -1, py: 2, pz: 3});
        send_point('{px: MAXC, py: 0, pz: 0});
        random_points(100);

        // Random planes; one long stretch without sender gaps.
        for (int ph = 0; ph < 5; ph++)
        begin
            set_plane(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            idle_on = (ph != 2);
            random_points(ph == 2 ? 250 : 90);
            if (ph == 1)
            begin
                // Hold off until the pipeline has drained, then resume.
                drain();
                random_points(20);
            end
        end
        idle_on = 1'b1;

        drain();
        repeat (LATENCY + 20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("point_plane_distance_projection_core: match");
        else
            $display("point_plane_distance_projection_core: mismatch");
        $finish;
    end
endmodule
